>>> design/size_class_free_list_top_macros.svh
// Assertion macros used by the free list back end
`ifndef SIZE_CLASS_FREE_LIST_TOP_MACROS_SVH
`define SIZE_CLASS_FREE_LIST_TOP_MACROS_SVH
`define SCFL_ASSERT_IMPL(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) else $error(msg);
`define SCFL_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) else $error(msg);
`endif

>>> design/scfl_pkg.sv
// ----------------------------------------------------------------------------
// scfl_pkg
// Shared types and constants of the size class free list.
// ----------------------------------------------------------------------------
package scfl_pkg;
  localparam int NUM_CLASSES_DEF = 8;
  localparam int LIST_DEPTH_DEF  = 64;
  localparam int NREGS           = 8;
  localparam int CLS_W           = 3;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_REM  = 2'd1;
  localparam logic [1:0] CMD_TAKE = 2'd2;
  localparam logic [1:0] CMD_PAGE = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_NOTF  = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_SIZE  = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        bad;
    logic [2:0]  cls;
    logic [31:0] addr;
    logic [15:0] size;
    logic [15:0] page;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] addr;
    logic [15:0] size;
    logic [2:0]  cls;
    logic [6:0]  cnt;
    logic [6:0]  removed;
  } res_t;

  localparam int REQ_W = $bits(req_t);
  localparam int RES_W = $bits(res_t);
endpackage

>>> design/size_class_free_list_top.sv
// ----------------------------------------------------------------------------
// size_class_free_list_top
// Segregated free lists, one bounded list per configurable size class.
// ----------------------------------------------------------------------------
// Requests enter through push/full and are classified by the limit registers
// in the same cycle, then wait in a two entry queue. The back end runs one
// request at a time against a single entry store RAM with registered read.
// Results leave through a two entry queue read with empty/pop.
// An add appends the entry to its class list. Take and remove by address
// search the list from its first slot, remove page examines every slot, and
// the last entry of the list refills each removed slot.
// A stalled receiver fills the result queue; the back end then holds its
// finished result and the request queue backs up into full.
// Synchronous reset empties all lists and loads the default class limits.
// The user writes the class limits through cfg_we/cfg_index/cfg_data only
// while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module size_class_free_list_top #(
  parameter int NUM_CLASSES = scfl_pkg::NUM_CLASSES_DEF,
  parameter int LIST_DEPTH  = scfl_pkg::LIST_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_block_addr,
  input  logic [15:0] in_block_size,
  input  logic [15:0] in_page_index,
  input  logic [2:0]  in_size_class,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic [31:0] out_out_addr,
  output logic [15:0] out_out_size,
  output logic [2:0]  out_class_index,
  output logic [6:0]  out_class_count,
  output logic [6:0]  out_removed_count
);
  import scfl_pkg::*;
  req_t req_in, req_q;
  res_t res_b, res_q;
  logic rq_empty, rq_pop, rs_push, rs_full;

  scfl_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(in_command), .addr(in_block_addr), .size(in_block_size), .page(in_page_index),
    .sclass(in_size_class), .req(req_in)
  );

  scfl_fifo #(.WIDTH(REQ_W)) u_rq (
    .clk(clk), .rst_n(rst_n), .push(push), .din(req_in), .full(full),
    .pop(rq_pop), .dout(req_q), .empty(rq_empty)
  );

  scfl_back #(.NUM_CLASSES(NUM_CLASSES), .LIST_DEPTH(LIST_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .req_valid(!rq_empty), .req(req_q), .req_pop(rq_pop),
    .res_valid(rs_push), .res(res_b), .res_full(rs_full)
  );

  scfl_fifo #(.WIDTH(RES_W)) u_rs (
    .clk(clk), .rst_n(rst_n), .push(rs_push), .din(res_b), .full(rs_full),
    .pop(pop), .dout(res_q), .empty(empty)
  );

  assign out_status        = res_q.status;
  assign out_out_addr      = res_q.addr;
  assign out_out_size      = res_q.size;
  assign out_class_index   = res_q.cls;
  assign out_class_count   = res_q.cnt;
  assign out_removed_count = res_q.removed;
endmodule

>>> design/scfl_ram.sv
// ----------------------------------------------------------------------------
// scfl_ram
// Generic single write, single read RAM with registered read.
// ----------------------------------------------------------------------------
module scfl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> design/scfl_fifo.sv
// ----------------------------------------------------------------------------
// scfl_fifo
// Two entry register queue.
// ----------------------------------------------------------------------------
module scfl_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  logic [WIDTH-1:0] q_r [2];
  logic             rd_r, wr_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign dout    = q_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_r] <= din;
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_r <= !wr_r;
      if (do_pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule

>>> design/scfl_front.sv
// ----------------------------------------------------------------------------
// scfl_front
// Holds the class limits and classifies each incoming request.
// ----------------------------------------------------------------------------
module scfl_front #(
  parameter int NUM_CLASSES = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic [1:0]            cmd,
  input  logic [31:0]           addr,
  input  logic [15:0]           size,
  input  logic [15:0]           page,
  input  logic [2:0]            sclass,
  output scfl_pkg::req_t        req
);
  import scfl_pkg::*;
  logic [15:0] lim_r [NREGS];
  logic        found;
  logic [2:0]  fcls;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREGS; i++) lim_r[i] <= 16'(16 << i);
    end else if (cfg_we) begin
      lim_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    found = 1'b0;
    fcls  = '0;
    for (int i = NREGS - 1; i >= 0; i--) begin
      if (i < NUM_CLASSES && size <= lim_r[i]) begin
        found = 1'b1;
        fcls  = 3'(i);
      end
    end
    req.cmd  = cmd;
    req.addr = addr;
    req.size = size;
    req.page = page;
    if (cmd == CMD_PAGE) begin
      req.cls = sclass;
      req.bad = 32'(sclass) >= NUM_CLASSES;
    end else begin
      req.cls = fcls;
      req.bad = !found;
    end
  end
endmodule

>>> design/scfl_back.sv
// ----------------------------------------------------------------------------
// scfl_back
// Executes requests on the class lists, one memory read per step.
// ----------------------------------------------------------------------------
module scfl_back #(
  parameter int NUM_CLASSES = 8,
  parameter int LIST_DEPTH  = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           req_valid,
  input  scfl_pkg::req_t req,
  output logic           req_pop,
  output logic           res_valid,
  output scfl_pkg::res_t res,
  input  logic           res_full
);
  import scfl_pkg::*;
  `include "size_class_free_list_top_macros.svh"
  localparam int JW = $clog2(LIST_DEPTH);
  localparam int FW = $clog2(LIST_DEPTH + 1);
  localparam int AW = $clog2(NUM_CLASSES * LIST_DEPTH);
  localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_CHK = 3'd2,
    S_LAST = 3'd3, S_MOVE = 3'd4, S_DONE = 3'd5;

  logic [2:0]    st_r, st_nxt;
  logic [FW-1:0] fill_r [NUM_CLASSES];
  req_t          q_r;
  logic [JW-1:0] j_r, j_nxt;
  logic [FW-1:0] rem_r, rem_nxt;
  logic [2:0]    stat_r, stat_nxt;
  logic [31:0]   oaddr_r, oaddr_nxt;
  logic [15:0]   osize_r, osize_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;
  logic [CW-1:0] ci;
  logic [FW-1:0] fill;
  logic          set_fill;
  logic [FW-1:0] fill_nxt;

  scfl_ram #(.WIDTH(64), .DEPTH(NUM_CLASSES * LIST_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign ci   = CW'(q_r.cls);
  assign fill = fill_r[ci];

  function automatic logic [AW-1:0] slot(input logic [CW-1:0] c, input logic [FW-1:0] j);
    slot = AW'(c) * AW'(LIST_DEPTH) + AW'(j);
  endfunction

  always_comb begin
    st_nxt    = st_r;
    j_nxt     = j_r;
    rem_nxt   = rem_r;
    stat_nxt  = stat_r;
    oaddr_nxt = oaddr_r;
    osize_nxt = osize_r;
    we        = 1'b0;
    waddr     = slot(ci, fill);
    wdata     = {q_r.page, q_r.size, q_r.addr};
    raddr     = slot(ci, FW'(j_r));
    set_fill  = 1'b0;
    fill_nxt  = fill;
    req_pop   = 1'b0;
    res_valid = 1'b0;
    case (st_r)
      S_IDLE: begin
        req_pop = req_valid;
        j_nxt   = '0;
        rem_nxt = '0;
        stat_nxt  = ST_OK;
        oaddr_nxt = '0;
        osize_nxt = '0;
        if (req_valid) st_nxt = S_RD;
      end
      S_RD: begin
        if (q_r.bad) begin
          stat_nxt = (q_r.cmd == CMD_PAGE) ? ST_OK : ST_SIZE;
          st_nxt = S_DONE;
        end else if (q_r.cmd == CMD_ADD) begin
          if (fill >= FW'(LIST_DEPTH)) stat_nxt = ST_FULL;
          else begin
            we = 1'b1;
            set_fill = 1'b1;
            fill_nxt = fill + 1'b1;
          end
          st_nxt = S_DONE;
        end else if (FW'(j_r) >= fill || (j_r == '0 && fill == '0 && FW'(j_r) >= fill)) begin
          if (q_r.cmd == CMD_REM) stat_nxt = ST_NOTF;
          if (q_r.cmd == CMD_TAKE) stat_nxt = ST_EMPTY;
          st_nxt = S_DONE;
        end else st_nxt = S_CHK;
      end
      S_CHK: begin
        raddr = slot(ci, fill - 1'b1);
        if ((q_r.cmd == CMD_TAKE) || (q_r.cmd == CMD_REM && rdata[31:0] == q_r.addr) ||
            (q_r.cmd == CMD_PAGE && rdata[63:48] == q_r.page)) begin
          if (q_r.cmd == CMD_TAKE) begin
            oaddr_nxt = rdata[31:0];
            osize_nxt = rdata[47:32];
          end
          rem_nxt = rem_r + 1'b1;
          st_nxt = S_LAST;
        end else begin
          if (q_r.cmd == CMD_REM && FW'(j_r) + 1'b1 >= fill) begin
            stat_nxt = ST_NOTF;
            st_nxt = S_DONE;
          end else if (FW'(j_r) + 1'b1 >= fill) st_nxt = S_DONE;
          else begin
            j_nxt = j_r + 1'b1;
            st_nxt = S_RD;
          end
        end
      end
      S_LAST: begin
        raddr = slot(ci, fill - 1'b1);
        st_nxt = S_MOVE;
      end
      S_MOVE: begin
        we = 1'b1;
        waddr = slot(ci, FW'(j_r));
        wdata = rdata;
        set_fill = 1'b1;
        fill_nxt = fill - 1'b1;
        st_nxt = (q_r.cmd == CMD_PAGE) ? S_RD : S_DONE;
      end
      S_DONE: begin
        res_valid = !res_full;
        if (!res_full) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res.status  = stat_r;
    res.addr    = oaddr_r;
    res.size    = osize_r;
    res.cls     = (q_r.bad && q_r.cmd != CMD_PAGE) ? 3'd0 : q_r.cls;
    res.cnt     = q_r.bad ? 7'd0 : 7'(fill);
    res.removed = 7'(rem_r);
  end

  always_ff @(posedge clk) begin
    if (req_pop) q_r <= req;
    j_r     <= j_nxt;
    rem_r   <= rem_nxt;
    stat_r  <= stat_nxt;
    oaddr_r <= oaddr_nxt;
    osize_r <= osize_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE;
      for (int i = 0; i < NUM_CLASSES; i++) fill_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (set_fill) fill_r[ci] <= fill_nxt;
    end
  end

  `SCFL_ASSERT_IMPL(a_fill_max, st_r != S_IDLE && !q_r.bad, fill <= FW'(LIST_DEPTH),
    "class fill above depth")
  `SCFL_ASSERT_IMPL(a_pop_idle, req_pop, st_r == S_IDLE, "request popped while busy")
  `SCFL_ASSERT_NEXT(a_done_idle, res_valid, st_r == S_IDLE, "result not retired")
endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Free list testbench: directed and random requests, checked against an
// in-bench model of the per-class lists, with random stalls and limit changes.
// ----------------------------------------------------------------------------
module tb_top;
  import scfl_pkg::*;

  localparam int NCLS  = 8;
  localparam int DEPTH = 64;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic [15:0] size;
    logic [15:0] page;
    logic [2:0]  cls;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] addr;
    logic [15:0] size;
    logic [2:0]  cls;
    logic [6:0]  cnt;
    logic [6:0]  removed;
  } outcome_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = 0;
  logic [15:0] cfg_data = 0;
  logic        push = 0;
  logic        full;
  logic [1:0]  in_command = 0;
  logic [31:0] in_block_addr = 0;
  logic [15:0] in_block_size = 0;
  logic [15:0] in_page_index = 0;
  logic [2:0]  in_size_class = 0;
  logic        empty;
  logic        pop = 0;
  logic [2:0]  out_status;
  logic [31:0] out_out_addr;
  logic [15:0] out_out_size;
  logic [2:0]  out_class_index;
  logic [6:0]  out_class_count;
  logic [6:0]  out_removed_count;

  size_class_free_list_top i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  logic [15:0] limits [NREGS];
  logic [31:0] ent_addr [NCLS][DEPTH];
  logic [15:0] ent_size [NCLS][DEPTH];
  logic [15:0] ent_page [NCLS][DEPTH];
  int          fill [NCLS];

  request_t pending_q[$];
  outcome_t expected_q[$];
  int errors = 0, n_pushed = 0, n_popped = 0, idle_cycles = 0;
  bit hold_off = 0;
  bit done = 0;
  int addr_pool_n = 0;

  function automatic int class_of(logic [15:0] s);
    for (int c = 0; c < NCLS; c++)
      if (s <= limits[c]) return c;
    return NCLS;
  endfunction

  task automatic drop_entry(int c, int j);
    int last;
    last = fill[c] - 1;
    ent_addr[c][j] = ent_addr[c][last];
    ent_size[c][j] = ent_size[c][last];
    ent_page[c][j] = ent_page[c][last];
    fill[c] = last;
  endtask

  task automatic predict_free_list(request_t r);
    outcome_t o;
    int c, j;
    o = '{default: 0};
    if (r.cmd == CMD_PAGE) begin
      o.cls = r.cls;
      c = r.cls;
      j = 0;
      while (j < fill[c]) begin
        if (ent_page[c][j] == r.page) begin
          drop_entry(c, j);
          o.removed++;
        end else j++;
      end
      o.cnt = 7'(fill[c]);
    end else begin
      c = class_of(r.size);
      if (c >= NCLS) o.status = ST_SIZE;
      else begin
        o.cls = 3'(c);
        if (r.cmd == CMD_ADD) begin
          if (fill[c] >= DEPTH) o.status = ST_FULL;
          else begin
            ent_addr[c][fill[c]] = r.addr;
            ent_size[c][fill[c]] = r.size;
            ent_page[c][fill[c]] = r.page;
            fill[c]++;
          end
        end else if (r.cmd == CMD_REM) begin
          for (j = 0; j < fill[c]; j++)
            if (ent_addr[c][j] == r.addr) break;
          if (j >= fill[c]) o.status = ST_NOTF;
          else begin
            drop_entry(c, j);
            o.removed = 1;
          end
        end else begin
          if (fill[c] == 0) o.status = ST_EMPTY;
          else begin
            o.addr = ent_addr[c][0];
            o.size = ent_size[c][0];
            drop_entry(c, 0);
            o.removed = 1;
          end
        end
        o.cnt = 7'(fill[c]);
      end
    end
    expected_q.push_back(o);
  endtask

  // driver
  int gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        predict_free_list(pending_q.pop_front());
        n_pushed++;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) gap = 0;
      end
      if (gap > 0) begin
        gap--;
        push <= 0;
      end else if (pending_q.size() > 0) begin
        push <= 1;
        in_command <= pending_q[0].cmd;
        in_block_addr <= pending_q[0].addr;
        in_block_size <= pending_q[0].size;
        in_page_index <= pending_q[0].page;
        in_size_class <= pending_q[0].cls;
      end else push <= 0;
    end
  end

  // monitor
  int stall = 0;
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n) begin
      if (pop && !empty) begin
        n_popped++;
        if (expected_q.size() == 0) begin
          $error("unexpected result");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_status); errors++; end
          if (out_out_addr !== e.addr) begin
            $error("out_addr exp %h got %h", e.addr, out_out_addr); errors++; end
          if (out_out_size !== e.size) begin
            $error("out_size exp %0d got %0d", e.size, out_out_size); errors++; end
          if (out_class_index !== e.cls) begin
            $error("class_index exp %0d got %0d", e.cls, out_class_index); errors++; end
          if (out_class_count !== e.cnt) begin
            $error("class_count exp %0d got %0d", e.cnt, out_class_count); errors++; end
          if (out_removed_count !== e.removed) begin
            $error("removed_count exp %0d got %0d", e.removed, out_removed_count);
            errors++;
          end
        end
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) stall = 0;
      end
      if (hold_off || stall > 0) begin
        if (stall > 0) stall--;
        pop <= 0;
      end else pop <= 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n && !done) begin
      if ((push && !full) || (pop && !empty) || cfg_we || hold_off) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_addr();
    return (addr_pool_n > 0 && $urandom_range(0, 3) != 0)
      ? 32'h1000 + $urandom_range(0, addr_pool_n - 1) : $urandom();
  endfunction

  task automatic queue_req(logic [1:0] cmd, logic [31:0] a, logic [15:0] s,
                           logic [15:0] p, logic [2:0] c);
    request_t r;
    r.cmd = cmd; r.addr = a; r.size = s; r.page = p; r.cls = c;
    pending_q.push_back(r);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_limit(int idx, logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx[2:0]; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    limits[idx] = v;
  endtask

  task automatic random_phase(int n);
    logic [1:0] cmd;
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(0, 9) < 5) ? CMD_ADD : 2'($urandom_range(1, 3));
      queue_req(cmd, cmd == CMD_ADD ? 32'h1000 + addr_pool_n : pick_addr(),
                $urandom_range(0, 7) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 2100)),
                $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 3)),
                3'($urandom()));
      if (cmd == CMD_ADD) addr_pool_n++;
    end
  endtask

  initial begin
    int hold;
    for (int i = 0; i < NREGS; i++) limits[i] = 16'd16 << i;
    for (int c = 0; c < NCLS; c++) fill[c] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed
    queue_req(CMD_TAKE, 0, 0, 0, 0);
    queue_req(CMD_REM, 32'hFFFF_FFFF, 16, 0, 0);
    queue_req(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 7);
    queue_req(CMD_ADD, 32'hFFFF_FFFF, 0, 16'hFFFF, 7);
    queue_req(CMD_ADD, 32'hFFFF_FFFF, 1, 0, 0);
    queue_req(CMD_ADD, 32'h0, 2048, 16'hFFFF, 0);
    queue_req(CMD_ADD, 32'h5, 2048, 16'hFFFF, 0);
    queue_req(CMD_REM, 32'hFFFF_FFFF, 3, 0, 0);
    queue_req(CMD_TAKE, 0, 2047, 0, 0);
    queue_req(CMD_PAGE, 0, 0, 16'hFFFF, 7);
    queue_req(CMD_PAGE, 0, 0, 16'h0, 0);
    queue_req(CMD_PAGE, 0, 0, 16'h1, 3);
    queue_req(CMD_REM, 32'h1234, 8, 0, 0);
    for (int i = 0; i < 66; i++) queue_req(CMD_ADD, 32'h100 + i, 17, 16'(i % 3), 0);
    drain();
    queue_req(CMD_PAGE, 0, 0, 16'h1, 1);
    queue_req(CMD_TAKE, 0, 20, 0, 0);
    drain();
    // extremes of limits
    for (int i = 0; i < NREGS; i++) write_limit(i, i == 7 ? 16'hFFFF : 16'h0);
    queue_req(CMD_ADD, 32'hA, 0, 2, 0);
    queue_req(CMD_ADD, 32'hB, 16'hFFFF, 2, 0);
    queue_req(CMD_TAKE, 0, 16'hFFFF, 0, 0);
    random_phase(60);
    drain();
    for (int i = 0; i < NREGS; i++) write_limit(i, 16'($urandom_range(0, 2100)));
    random_phase(100);
    // long receiver hold while requests keep coming
    hold_off = 1;
    hold = 0;
    while (hold < 400) begin
      @(posedge clk);
      hold++;
    end
    hold_off = 0;
    drain();
    for (int i = 0; i < NREGS; i++) write_limit(i, 16'd16 << i);
    random_phase(150);
    drain();
    done = 1;
    $display("Ran %0d requests, %0d results, through four limit settings", n_pushed,
             n_popped);
    $display("including full lists, empty takes, page purges and long output stalls.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+design
design/scfl_pkg.sv
design/scfl_ram.sv
design/scfl_fifo.sv
design/scfl_front.sv
design/scfl_back.sv
design/size_class_free_list_top.sv
test/tb_top.sv
